[hdl/pli_pkg.sv]
// Shared widths, codes and the breakpoint entry type for the piecewise-linear
// interpolator. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package pli_pkg;

  // Table geometry
  localparam int MAX_POINTS = 16;
  localparam int IDX_W      = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CNT_W      = $clog2(MAX_POINTS + 1);

  // Fixed field widths
  localparam int CFG_W      = 5;
  localparam int ENTRY_W    = 4;
  localparam int XW         = 12;
  localparam int YW         = 12;
  localparam int RES_W      = 32;
  localparam int STATUS_W   = 2;

  // Fixed-point arithmetic
  localparam int FRAC_BITS  = 8;
  localparam int DX_W       = XW + 1;
  localparam int DY_W       = YW + 1;
  localparam int PROD_W     = DX_W + DY_W;
  localparam int MAG_W      = XW + YW + FRAC_BITS;
  localparam int DIV_CNT_W  = $clog2(MAG_W);
  localparam int SUM_W      = (MAG_W + 2 > RES_W + 1) ? MAG_W + 2 : RES_W + 1;

  // Item kinds
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_EVAL  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOSEG = 2'd2;

  typedef struct packed {
    logic [XW-1:0] x;
    logic [YW-1:0] y;
  } entry_t;

endpackage

`default_nettype wire

[hdl/piecewise_linear_interpolator.sv]
// Top level of the piecewise-linear interpolator: sequencer, table scan and
// fixed-point datapath. Depends on pli_pkg, pli_ram and pli_div.
//
// Usage
//   Configuration: cfg_we_i / cfg_wdata_i write points_in_use (breakpoints in
//   use, clamped to the table depth). Write it only while busy is low.
//   Command channel: a beat is taken at a rising edge with start high and busy
//   low. kind_i = 0 stores (point_x_i, point_y_i) in slot entry_index_i;
//   kind_i = 1 maps query_x_i through the table.
//   Result channel: done_o is high for exactly one cycle with result_y_o
//   (Q23.8, saturated) and status_o. Every command gives one result beat and
//   the receiver cannot hold it off, so results are never queued.
//   Sequence: a write, or a query with fewer than two points in use, answers
//   in the next cycle. Any other query streams the table through the single
//   memory read port, picks the segment (an exact hit or a query with no
//   segment answers there), fetches it, forms the product (a zero span answers
//   there), starts the divider, which gives one quotient bit per cycle of its
//   32-bit quotient and then flags the end, and registers the result beat.
//   One command is in flight at a time; busy stays high until the result.
//   Reset clears the sequencer and points_in_use; table contents stay
//   undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module piecewise_linear_interpolator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [pli_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          kind_i,
  input  logic [pli_pkg::ENTRY_W-1:0]   entry_index_i,
  input  logic [pli_pkg::XW-1:0]        point_x_i,
  input  logic [pli_pkg::YW-1:0]        point_y_i,
  input  logic [pli_pkg::XW-1:0]        query_x_i,
  output logic                          done_o,
  output logic signed [pli_pkg::RES_W-1:0] result_y_o,
  output logic [pli_pkg::STATUS_W-1:0]  status_o
);
  import pli_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_SEL,
    S_RD0,
    S_RD1,
    S_MUL,
    S_DIVGO,
    S_DIVW
  } state_e;

  localparam logic signed [SUM_W-1:0] SAT_HI =
    {{(SUM_W - RES_W + 1){1'b0}}, {(RES_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic [RES_W-1:0] RES_MAX = {1'b0, {(RES_W - 1){1'b1}}};
  localparam logic [RES_W-1:0] RES_MIN = {1'b1, {(RES_W - 1){1'b0}}};

  // Control and result registers
  state_e                  state_q;
  logic                    done_q;
  logic [RES_W-1:0]        res_q;
  logic [STATUS_W-1:0]     status_q;
  logic                    rvld_q;
  logic [CFG_W-1:0]        cfg_q;

  // Scan and datapath registers
  logic [CNT_W-1:0]        n_q;
  logic [XW-1:0]           q_q;
  logic [CNT_W-1:0]        ptr_q;
  logic [CNT_W-1:0]        ridx_q;
  logic                    match_q;
  logic [YW-1:0]           match_y_q;
  logic                    seg_q;
  logic [IDX_W-1:0]        seg_idx_q;
  logic [XW-1:0]           xfirst_q;
  logic [XW-1:0]           xlast_q;
  logic [XW-1:0]           prev_x_q;
  logic [IDX_W-1:0]        base_q;
  entry_t                  e0_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [DX_W-1:0]  dx_q;
  logic                    neg_q;

  // Combinational signals
  logic [CNT_W-1:0]        n_lim;
  logic                    accept;
  logic                    issue;
  logic                    q_lo;
  logic                    q_hi;
  logic                    mem_we;
  entry_t                  wr_entry;
  logic [IDX_W-1:0]        mem_raddr;
  entry_t                  rd_data;
  logic signed [DX_W-1:0]  dx_w;
  logic signed [DY_W-1:0]  dy_w;
  logic signed [DX_W-1:0]  dq_w;
  logic [PROD_W-1:0]       prod_abs;
  logic [DX_W-1:0]         dx_abs;
  logic                    div_start;
  logic [MAG_W-1:0]        div_dividend;
  logic                    div_done;
  logic [MAG_W-1:0]        div_quot;
  logic signed [SUM_W-1:0] quot_s;
  logic signed [SUM_W-1:0] base_s;
  logic signed [SUM_W-1:0] sum_w;
  logic [RES_W-1:0]        res_sat;

  // Clamp the configured count to the table depth
  always_comb begin
    if (int'(cfg_q) > MAX_POINTS) begin
      n_lim = CNT_W'(MAX_POINTS);
    end else begin
      n_lim = CNT_W'(cfg_q);
    end
  end

  assign accept = start && (state_q == S_IDLE);
  assign issue  = (state_q == S_SCAN) && (ptr_q < n_q);
  assign q_lo   = q_q < xfirst_q;
  assign q_hi   = q_q > xlast_q;

  // Drop writes to slots beyond the table
  assign mem_we = accept && (kind_i == KIND_WRITE) && (int'(entry_index_i) < MAX_POINTS);
  assign wr_entry = {point_x_i, point_y_i};

  // One read port: stream during the scan, then fetch the chosen segment
  always_comb begin
    unique case (state_q)
      S_SCAN:  mem_raddr = ptr_q[IDX_W-1:0];
      S_RD0:   mem_raddr = base_q;
      S_RD1:   mem_raddr = IDX_W'(base_q + 1'b1);
      default: mem_raddr = '0;
    endcase
  end

  pli_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (IDX_W'(entry_index_i)),
    .wdata_i (wr_entry),
    .raddr_i (mem_raddr),
    .rdata_o (rd_data)
  );

  // Segment differences: the far end arrives from the memory in S_MUL
  assign dx_w = $signed({1'b0, rd_data.x}) - $signed({1'b0, e0_q.x});
  assign dy_w = $signed({1'b0, rd_data.y}) - $signed({1'b0, e0_q.y});
  assign dq_w = $signed({1'b0, q_q}) - $signed({1'b0, e0_q.x});

  // Divide magnitudes, restore the sign afterwards (truncation toward zero)
  assign prod_abs     = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
  assign dx_abs       = dx_q[DX_W-1] ? DX_W'(-dx_q) : DX_W'(dx_q);
  assign div_start    = (state_q == S_DIVGO);
  assign div_dividend = MAG_W'(prod_abs[XW+YW-1:0]) << FRAC_BITS;

  pli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (dx_abs[XW-1:0]),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign quot_s = neg_q ? -$signed(SUM_W'(div_quot)) : $signed(SUM_W'(div_quot));
  assign base_s = $signed(SUM_W'(e0_q.y) << FRAC_BITS);
  assign sum_w  = base_s + quot_s;

  always_comb begin
    priority if (sum_w > SAT_HI) begin
      res_sat = RES_MAX;
    end else if (sum_w < SAT_LO) begin
      res_sat = RES_MIN;
    end else begin
      res_sat = sum_w[RES_W-1:0];
    end
  end

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Sequencer with its registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      done_q   <= 1'b0;
      res_q    <= '0;
      status_q <= ST_OK;
      rvld_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      rvld_q <= issue;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            if (kind_i == KIND_WRITE) begin
              done_q   <= 1'b1;
              res_q    <= '0;
              status_q <= ST_OK;
            end else if (n_lim < CNT_W'(2)) begin
              done_q   <= 1'b1;
              res_q    <= '0;
              status_q <= ST_BAD;
            end else begin
              state_q <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // Advance once the last entry has come back
          if (rvld_q && (ridx_q == n_q - 1'b1)) begin
            state_q <= S_SEL;
          end
        end
        S_SEL: begin
          priority if (match_q) begin
            done_q   <= 1'b1;
            res_q    <= RES_W'(match_y_q) << FRAC_BITS;
            status_q <= ST_OK;
            state_q  <= S_IDLE;
          end else if (q_lo || q_hi || seg_q) begin
            state_q <= S_RD0;
          end else begin
            done_q   <= 1'b1;
            res_q    <= '0;
            status_q <= ST_NOSEG;
            state_q  <= S_IDLE;
          end
        end
        S_RD0: begin
          state_q <= S_RD1;
        end
        S_RD1: begin
          state_q <= S_MUL;
        end
        S_MUL: begin
          if (dx_w == '0) begin
            done_q   <= 1'b1;
            res_q    <= '0;
            status_q <= ST_BAD;
            state_q  <= S_IDLE;
          end else begin
            state_q <= S_DIVGO;
          end
        end
        S_DIVGO: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          if (div_done) begin
            done_q   <= 1'b1;
            res_q    <= res_sat;
            status_q <= ST_OK;
            state_q  <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Scan bookkeeping and datapath
  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == KIND_EVAL)) begin
      n_q     <= n_lim;
      q_q     <= query_x_i;
      ptr_q   <= '0;
      match_q <= 1'b0;
      seg_q   <= 1'b0;
    end
    if (state_q == S_SCAN) begin
      if (issue) begin
        ptr_q <= ptr_q + 1'b1;
      end
      ridx_q <= ptr_q;
      if (rvld_q) begin
        // Keep the first exact hit and the first enclosing segment
        if (!match_q && (rd_data.x == q_q)) begin
          match_q   <= 1'b1;
          match_y_q <= rd_data.y;
        end
        if (ridx_q == '0) begin
          xfirst_q <= rd_data.x;
        end
        if ((ridx_q != '0) && !seg_q && (prev_x_q <= q_q) && (q_q <= rd_data.x)) begin
          seg_q     <= 1'b1;
          seg_idx_q <= IDX_W'(ridx_q - 1'b1);
        end
        prev_x_q <= rd_data.x;
        xlast_q  <= rd_data.x;
      end
    end
    if (state_q == S_SEL) begin
      // Extrapolate below along the first segment, above along the last
      priority if (q_lo) begin
        base_q <= '0;
      end else if (q_hi) begin
        base_q <= IDX_W'(n_q - CNT_W'(2));
      end else begin
        base_q <= seg_idx_q;
      end
    end
    if (state_q == S_RD1) begin
      e0_q <= rd_data;
    end
    if (state_q == S_MUL) begin
      prod_q <= dy_w * dq_w;
      dx_q   <= dx_w;
    end
    if (state_q == S_DIVGO) begin
      neg_q <= prod_q[PROD_W-1] ^ dx_q[DX_W-1];
    end
  end

  assign busy       = (state_q != S_IDLE);
  assign done_o     = done_q;
  assign result_y_o = res_q;
  assign status_o   = status_q;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> (result_y_o == '0))
    else $error("non-zero result with an error status");

  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (done_o || busy))
    else $error("accepted command neither answered nor in progress");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rvld_q |-> (ridx_q < n_q) && (state_q == S_SCAN))
    else $error("table read returned beyond the points in use");

  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIVW))
    else $error("divider finished outside its wait state");
`endif

endmodule

`default_nettype wire

[hdl/pli_ram.sv]
// Breakpoint table: one write port, one read port, registered read data.
// Depends on pli_pkg for the entry type and depth.
`timescale 1ns / 1ps
`default_nettype none

module pli_ram (
  input  logic                   clk_i,
  input  logic                   we_i,
  input  logic [pli_pkg::IDX_W-1:0] waddr_i,
  input  pli_pkg::entry_t        wdata_i,
  input  logic [pli_pkg::IDX_W-1:0] raddr_i,
  output pli_pkg::entry_t        rdata_o
);
  import pli_pkg::*;

  entry_t mem [MAX_POINTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[hdl/pli_div.sv]
// Bit-serial restoring divider for unsigned magnitudes, one quotient bit per
// cycle. Depends on pli_pkg for the operand widths.
`timescale 1ns / 1ps
`default_nettype none

module pli_div (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [pli_pkg::MAG_W-1:0] dividend_i,
  input  logic [pli_pkg::XW-1:0]  divisor_i,
  output logic                    done_o,
  output logic [pli_pkg::MAG_W-1:0] quot_o
);
  import pli_pkg::*;

  logic                 busy_q;
  logic                 done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [XW-1:0]        rem_q;
  logic [XW-1:0]        div_q;
  logic [MAG_W-1:0]     quo_q;

  logic [XW:0]          trial;
  logic [XW:0]          diff;
  logic                 fits;

  assign trial = {rem_q, quo_q[MAG_W-1]};
  assign fits  = (trial >= {1'b0, div_q});
  assign diff  = trial - {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= DIV_CNT_W'(MAG_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift the dividend out as quotient bits shift in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      div_q <= divisor_i;
      quo_q <= dividend_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[XW-1:0] : trial[XW-1:0];
      quo_q <= {quo_q[MAG_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");

  a_start_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q && (cnt_q == DIV_CNT_W'(MAG_W - 1)))
    else $error("divider did not load its bit count");

  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_q) && !busy_q)
    else $error("divider done outside the end of a division");
`endif

endmodule

`default_nettype wire

[tb/sv/piecewise_linear_interpolator_tb.sv]
// Self-checking testbench for the piecewise-linear interpolator: directed
// corner cases, then random breakpoint tables and queries under random idling.
// Depends on pli_pkg and piecewise_linear_interpolator.
`timescale 1ns / 1ps

module piecewise_linear_interpolator_tb;
  import pli_pkg::*;

  localparam int RANDOM_ITEMS_TARGET = 1600;
  localparam int WATCHDOG_LIMIT      = 2000;
  localparam int DRAIN_SETTLE        = 2;
  localparam int END_SETTLE          = 64;
  localparam int PRINT_CAP           = 40;

  // One result beat as the block should present it
  typedef struct {
    logic signed [RES_W-1:0] y;
    logic [STATUS_W-1:0]     st;
  } mapped_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    cfg_we_i;
  logic [CFG_W-1:0]        cfg_wdata_i;
  logic                    start;
  logic                    busy;
  logic                    kind_i;
  logic [ENTRY_W-1:0]      entry_index_i;
  logic [XW-1:0]           point_x_i;
  logic [YW-1:0]           point_y_i;
  logic [XW-1:0]           query_x_i;
  logic                    done_o;
  logic signed [RES_W-1:0] result_y_o;
  logic [STATUS_W-1:0]     status_o;

  // Shadow of the breakpoint table and the point count, kept in step with
  // every accepted beat and every register write
  logic [XW-1:0]           bp_x [MAX_POINTS];
  logic [YW-1:0]           bp_y [MAX_POINTS];
  logic [CFG_W-1:0]        pts_in_use;

  mapped_result_t          mapped_results_due[$];
  int                      mismatches;
  int                      items_accepted;
  int                      idle_cycles;
  bit                      gaps_on;

  piecewise_linear_interpolator uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .start         (start),
    .busy          (busy),
    .kind_i        (kind_i),
    .entry_index_i (entry_index_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .query_x_i     (query_x_i),
    .done_o        (done_o),
    .result_y_o    (result_y_o),
    .status_o      (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Evaluate along the segment between slots a and b; a zero span gives 0.
  function automatic bit segment_value(input int a, input int b,
                                       input logic [XW-1:0] q, output longint v);
    longint x0, y0, x1, y1, dx, num, one;
    x0  = bp_x[a];
    y0  = bp_y[a];
    x1  = bp_x[b];
    y1  = bp_y[b];
    dx  = x1 - x0;
    one = longint'(1) << FRAC_BITS;
    v   = 0;
    if (dx == 0) return 1'b0;
    num = (y1 - y0) * (longint'(q) - x0) * one;
    // SystemVerilog division truncates toward zero, as the block does
    v = y0 * one + num / dx;
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return 1'b1;
  endfunction

  // Map one query through the shadow table
  function automatic void predict_mapped(input logic [XW-1:0] q,
                                         output logic signed [RES_W-1:0] ry,
                                         output logic [STATUS_W-1:0] st);
    int     n;
    bit     found;
    longint v;
    n     = (pts_in_use > MAX_POINTS) ? MAX_POINTS : int'(pts_in_use);
    found = 1'b0;
    v     = 0;
    st    = ST_OK;
    if (n < 2) begin
      ry = '0;
      st = ST_BAD;
      return;
    end
    // An exact hit on a breakpoint wins over everything else
    for (int i = 0; i < n; i++) begin
      if (!found && bp_x[i] == q) begin
        v     = longint'(bp_y[i]) << FRAC_BITS;
        found = 1'b1;
      end
    end
    // Below the first point: extend the first segment
    if (!found && q < bp_x[0]) begin
      if (!segment_value(0, 1, q, v)) st = ST_BAD;
      found = 1'b1;
    end
    // Above the last point: extend the last segment
    if (!found && q > bp_x[n-1]) begin
      if (!segment_value(n - 2, n - 1, q, v)) st = ST_BAD;
      found = 1'b1;
    end
    // Otherwise take the first segment that brackets the query
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && bp_x[i] <= q && q <= bp_x[i+1]) begin
        if (!segment_value(i, i + 1, q, v)) st = ST_BAD;
        found = 1'b1;
      end
    end
    if (!found) st = ST_NOSEG;
    if (st != ST_OK) v = 0;
    ry = v[RES_W-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  function automatic logic [YW-1:0] pick_y();
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    return YW'($urandom);
  endfunction

  // Bias queries toward breakpoints, their neighbours and the ends of the range
  function automatic logic [XW-1:0] pick_query(input int eff);
    int r, s;
    r = $urandom_range(0, 99);
    if (eff < 2 || r < 40) return XW'($urandom);
    s = $urandom_range(0, eff - 1);
    if (r < 60) return bp_x[s];
    if (r < 75) return $urandom_range(0, 1) ? bp_x[s] + 1'b1 : bp_x[s] - 1'b1;
    if (r < 85) return $urandom_range(0, 1) ? 12'hFFF : 12'h000;
    if (r < 93) return (bp_x[0] == 0) ? 12'h000 : XW'($urandom_range(0, bp_x[0] - 1));
    return (bp_x[eff-1] == 12'hFFF) ? 12'hFFF
                                    : XW'($urandom_range(bp_x[eff-1] + 1, 4095));
  endfunction

  // Present one beat, hold it until taken and record what it should return.
  // Call at a rising edge; returns at the edge that took the beat, start high.
  task automatic send_beat(input logic kind, input logic [ENTRY_W-1:0] idx,
                           input logic [XW-1:0] px, input logic [YW-1:0] py,
                           input logic [XW-1:0] q);
    int             gap;
    mapped_result_t due;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    kind_i        <= kind;
    entry_index_i <= idx;
    point_x_i     <= px;
    point_y_i     <= py;
    query_x_i     <= q;
    start         <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (kind == KIND_WRITE) begin
      bp_x[idx] = px;
      bp_y[idx] = py;
      due.y     = '0;
      due.st    = ST_OK;
    end else begin
      predict_mapped(q, due.y, due.st);
    end
    mapped_results_due.push_back(due);
    items_accepted++;
  endtask

  task automatic send_write(input int idx, input logic [XW-1:0] px,
                            input logic [YW-1:0] py);
    send_beat(KIND_WRITE, ENTRY_W'(idx), px, py, XW'($urandom));
  endtask

  task automatic send_query(input logic [XW-1:0] q);
    send_beat(KIND_EVAL, ENTRY_W'($urandom), XW'($urandom), YW'($urandom), q);
  endtask

  // Drop start and hold off until every due result has come and busy is low
  task automatic wait_for_drain();
    start <= 1'b0;
    while (mapped_results_due.size() != 0 || busy) @(posedge clk_i);
    repeat (DRAIN_SETTLE) @(posedge clk_i);
  endtask

  // Write the point count; only ever done with the block idle
  task automatic set_points(input logic [CFG_W-1:0] v);
    wait_for_drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    pts_in_use  = v;
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("%0t: mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Short table: with no points in use nothing is read
  task automatic test_short_table();
    send_query(12'hFFF);
    send_query(12'h000);
  endtask

  // Steep end segments drive the extrapolation into both saturation limits
  task automatic test_extrapolation_saturation();
    send_write(0, 12'd1000, 12'h000);
    send_write(1, 12'd1001, 12'hFFF);
    set_points(5'd1);
    send_query(12'h000);
    set_points(5'd2);
    send_query(12'hFFF);
    send_query(12'h000);
    send_query(12'd1000);
    send_write(0, 12'd1000, 12'hFFF);
    send_write(1, 12'd1001, 12'h000);
    send_query(12'hFFF);
  endtask

  // Zero span: both end segments collapse onto the same x
  task automatic test_zero_span();
    send_write(1, 12'd1000, 12'd7);
    send_query(12'd5);
    send_query(12'hFFF);
  endtask

  // Interpolation inside a four-point table, rising and falling segments
  task automatic test_interpolation();
    set_points(5'd4);
    send_write(0, 12'd0,    12'd0);
    send_write(1, 12'd1365, 12'hFFF);
    send_write(2, 12'd2730, 12'd100);
    send_write(3, 12'hFFF,  12'hFFF);
    send_query(12'd700);
    send_query(12'd2000);
    send_query(12'hFFF);
    send_query(12'h000);
  endtask

  // A table that is not ascending: first bracketing segment must be taken
  task automatic test_unordered_table();
    send_write(2, 12'd500, 12'd2000);
    send_query(12'd1000);
    send_query(12'd3000);
  endtask

  // Random phases: set a point count, load the slots in use, then query hard
  task automatic test_random_phases();
    int               phase, eff, style, base, nq, r;
    logic [CFG_W-1:0] pts;
    int               xs[$];
    phase = 0;
    while (items_accepted < RANDOM_ITEMS_TARGET) begin
      // Walk the extremes of the count first, then draw it
      case (phase)
        0: pts = 5'd16;
        1: pts = 5'd17;
        2: pts = 5'd31;
        3: pts = 5'd2;
        4: pts = 5'd0;
        5: pts = 5'd1;
        default: begin
          r = $urandom_range(0, 9);
          if (r < 7)      pts = CFG_W'($urandom_range(2, 16));
          else if (r < 9) pts = CFG_W'($urandom_range(17, 31));
          else            pts = CFG_W'($urandom_range(0, 1));
        end
      endcase
      set_points(pts);
      eff     = (pts > MAX_POINTS) ? MAX_POINTS : int'(pts);
      gaps_on = ($urandom_range(0, 3) != 0);

      // Mostly ascending tables; narrow ones give repeated x, a few are unordered
      style = $urandom_range(0, 9);
      base  = $urandom_range(0, 4088);
      xs.delete();
      for (int i = 0; i < eff; i++) begin
        if (style >= 6 && style < 8) xs.push_back(base + $urandom_range(0, 7));
        else                         xs.push_back($urandom_range(0, 4095));
      end
      if (style < 8) xs.sort();
      for (int i = 0; i < eff; i++) send_write(i, XW'(xs[i]), pick_y());

      // Now and then let everything drain before the queries start
      if (phase % 5 == 4) wait_for_drain();

      nq = (eff < 2) ? 8 : $urandom_range(30, 60);
      repeat (nq) begin
        if ($urandom_range(0, 99) < 8)
          send_write($urandom_range(0, MAX_POINTS - 1), XW'($urandom), pick_y());
        else
          send_query(pick_query(eff));
      end
      phase++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: every done beat against the oldest due result
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : check_results
    mapped_result_t head;
    if (rst_ni && done_o) begin
      if (mapped_results_due.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing due (y=%0d st=%0d)",
                                  result_y_o, status_o));
      end else begin
        head = mapped_results_due.pop_front();
        if (result_y_o !== head.y)
          report_mismatch($sformatf("result_y %0d, want %0d", result_y_o, head.y));
        if (status_o !== head.st)
          report_mismatch($sformatf("status %0d, want %0d", status_o, head.st));
      end
    end
  end

  // Watchdog: end the run if no beat moves either way for too long
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) idle_cycles <= 0;
    else                                       idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_wdata_i    <= '0;
    start          <= 1'b0;
    kind_i         <= KIND_WRITE;
    entry_index_i  <= '0;
    point_x_i      <= '0;
    point_y_i      <= '0;
    query_x_i      <= '0;
    pts_in_use     = '0;
    mismatches     = 0;
    items_accepted = 0;
    gaps_on        = 1'b1;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_short_table();
    test_extrapolation_saturation();
    test_zero_span();
    test_interpolation();
    test_unordered_table();
    test_random_phases();

    // Drain the last results, then give the block time to show a stray beat
    wait_for_drain();
    repeat (END_SETTLE) @(posedge clk_i);
    if (mismatches == 0 && mapped_results_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[files.f]
hdl/pli_pkg.sv
hdl/pli_ram.sv
hdl/pli_div.sv
hdl/piecewise_linear_interpolator.sv
tb/sv/piecewise_linear_interpolator_tb.sv
